### design/gsof_pkg.sv
// Shared constants, types and tables for the rotated square overlap filter.
`default_nettype none
package gsof_pkg;

    localparam int MAX_SQUARES  = 256;
    localparam int IDX_W        = $clog2(MAX_SQUARES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int SIDE_W       = 23;
    localparam int COORD_W      = 24;
    localparam int TRIG_W       = 18;
    localparam int PT_W         = 26;
    localparam int MA_W         = 28;
    localparam int MB_W         = 26;
    localparam int PROD_W       = MA_W + MB_W;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 23'd104858;
    localparam logic signed [31:0] CORDIC_INIT = 32'sd652032875;

    localparam logic       OP_CLEAR        = 1'b1;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP  = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_CLEARED  = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [TRIG_W-1:0]  co;
        logic signed [TRIG_W-1:0]  si;
    } t_entry;

    function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            4'd0:  v = 32'sd536870912;
            4'd1:  v = 32'sd316933406;
            4'd2:  v = 32'sd167458907;
            4'd3:  v = 32'sd85004756;
            4'd4:  v = 32'sd42667331;
            4'd5:  v = 32'sd21354465;
            4'd6:  v = 32'sd10679838;
            4'd7:  v = 32'sd5340245;
            4'd8:  v = 32'sd2670163;
            4'd9:  v = 32'sd1335087;
            4'd10: v = 32'sd667544;
            4'd11: v = 32'sd333772;
            4'd12: v = 32'sd166886;
            4'd13: v = 32'sd83443;
            4'd14: v = 32'sd41722;
            4'd15: v = 32'sd20861;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/gsof_cordic.sv
// Iterative CORDIC giving cosine and sine of a 16-bit turn fraction.
`default_nettype none
module gsof_cordic import gsof_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [15:0]               i_angle,
    output logic                     o_done,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_i, n_i;
    logic [1:0]          r_q, n_q;
    logic signed [31:0]  r_x, n_x, r_y, n_y, r_z, n_z;
    logic [15:0]         w_qsum;
    logic signed [31:0]  w_dx, w_dy, w_xr, w_yr, w_at;
    logic signed [TRIG_W-1:0] w_cr, w_sr;

    assign w_qsum = i_angle + 16'h2000;
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_at   = atan_turn(r_i);
    assign w_xr   = r_x + 32'sd8192;
    assign w_yr   = r_y + 32'sd8192;
    assign w_cr   = w_xr[31:14];
    assign w_sr   = w_yr[31:14];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_i    = r_i;
        n_q    = r_q;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_start) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_q    = w_qsum[15:14];
            n_x    = CORDIC_INIT;
            n_y    = '0;
            n_z    = {i_angle, 16'h0000} - {w_qsum[15:14], 30'd0};
        end else if (r_busy) begin
            if (!r_z[31]) begin
                n_x = r_x - w_dx;
                n_y = r_y + w_dy;
                n_z = r_z - w_at;
            end else begin
                n_x = r_x + w_dx;
                n_y = r_y - w_dy;
                n_z = r_z + w_at;
            end
            n_i = r_i + 1'b1;
            if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i <= n_i;
        r_q <= n_q;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    always_comb begin
        case (r_q)
            QUAD_0: begin o_cos = w_cr;  o_sin = w_sr;  end
            QUAD_1: begin o_cos = -w_sr; o_sin = w_cr;  end
            QUAD_2: begin o_cos = -w_cr; o_sin = -w_sr; end
            default: begin o_cos = w_sr; o_sin = -w_cr; end
        endcase
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

### design/greedy_square_overlap_filter.sv
// Top level: greedy filter that keeps equal rotated squares that overlap no kept square.
// A clear request goes straight from idle to the result state. A submit request runs the
// CORDIC iterations, registers the result and forms the own corners, then walks the
// stored table through one synchronous memory port: an entry that fails the center-distance
// pretest is passed over, and one that passes it gets 8 corner tests through four shared
// multipliers, ending early at the first overlap, before the result is handed off. One
// request is in work at a time; a new one is taken while the previous result still waits
// on the output register.
`default_nettype none
module greedy_square_overlap_filter import gsof_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [1:0]                  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_op,
    input  wire signed [COORD_W-1:0]   i_center_x,
    input  wire signed [COORD_W-1:0]   i_center_y,
    input  wire [15:0]                 i_angle,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_slot,
    output logic signed [COORD_W-1:0]  o_corner_a_x,
    output logic signed [COORD_W-1:0]  o_corner_a_y,
    output logic signed [COORD_W-1:0]  o_corner_b_x,
    output logic signed [COORD_W-1:0]  o_corner_b_y,
    output logic signed [COORD_W-1:0]  o_corner_c_x,
    output logic signed [COORD_W-1:0]  o_corner_c_y,
    output logic signed [COORD_W-1:0]  o_corner_d_x,
    output logic signed [COORD_W-1:0]  o_corner_d_y
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CORD  = 9'b000000010,
        ST_PROD  = 9'b000000100,
        ST_OWN   = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_EPROD = 9'b000100000,
        ST_ECHK  = 9'b001000000,
        ST_TEST  = 9'b010000000,
        ST_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [SIDE_W-1:0]          r_side;
    logic [CNT_W-1:0]           r_count;
    logic [IDX_W-1:0]           r_j;
    logic [3:0]                 r_k;
    logic                       r_kv, r_hit, r_clr;
    logic signed [COORD_W-1:0]  r_cx, r_cy;
    logic signed [TRIG_W-1:0]   r_co, r_si;
    logic [47:0]                r_side2;
    logic signed [PT_W-1:0]     r_nx [4];
    logic signed [PT_W-1:0]     r_ny [4];
    logic signed [PT_W-1:0]     r_ox [4];
    logic signed [PT_W-1:0]     r_oy [4];
    logic signed [PROD_W-1:0]   r_p [4];
    logic signed [MA_W-1:0]     n_ma [4];
    logic signed [MB_W-1:0]     n_mb [4];

    t_entry                     r_mem [MAX_SQUARES];
    t_entry                     r_q;
    logic                       w_we;

    logic                       r_ov;
    logic [1:0]                 r_status;
    logic [7:0]                 r_slot;
    logic signed [COORD_W-1:0]  r_ocx [4];
    logic signed [COORD_W-1:0]  r_ocy [4];

    logic                       w_accept, w_load, w_last, w_close, w_hit, w_cord_done;
    logic signed [TRIG_W-1:0]   w_cos, w_sin;
    logic signed [PT_W-1:0]     w_hc, w_hs, w_shc, w_shs, w_px, w_py, w_ax, w_ay;
    logic signed [PT_W:0]       w_tx, w_ty;
    logic signed [TRIG_W-1:0]   w_fco, w_fsi;
    logic signed [COORD_W:0]    w_dx, w_dy;
    logic signed [PROD_W:0]     w_rx, w_ry, w_ax2, w_ay2;
    logic [PROD_W+1:0]          w_lim;
    logic signed [PROD_W:0]     w_dist;
    logic signed [MA_W-1:0]     w_side_a;
    logic signed [MB_W-1:0]     w_side_b;

    function automatic logic signed [PT_W-1:0] half_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(65536);
        return t[PT_W+16:17];
    endfunction

    function automatic logic signed [PT_W-1:0] corner_x(input logic signed [COORD_W-1:0] c,
            input logic signed [PT_W-1:0] hc, input logic signed [PT_W-1:0] hs,
            input logic [1:0] k);
        logic signed [PT_W-1:0] e;
        e = PT_W'(c);
        case (k)
            2'd0: return e + hc - hs;
            2'd1: return e - hc - hs;
            2'd2: return e - hc + hs;
            default: return e + hc + hs;
        endcase
    endfunction

    function automatic logic signed [PT_W-1:0] corner_y(input logic signed [COORD_W-1:0] c,
            input logic signed [PT_W-1:0] hc, input logic signed [PT_W-1:0] hs,
            input logic [1:0] k);
        logic signed [PT_W-1:0] e;
        e = PT_W'(c);
        case (k)
            2'd0: return e + hs + hc;
            2'd1: return e - hs + hc;
            2'd2: return e - hs - hc;
            default: return e + hs - hc;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [PT_W-1:0] v);
        if (v[PT_W-1:COORD_W-1] == '0 || v[PT_W-1:COORD_W-1] == '1) begin
            return v[COORD_W-1:0];
        end
        return v[PT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    gsof_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && i_op != OP_CLEAR),
        .i_angle (i_angle),
        .o_done  (w_cord_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {9'd0, r_side} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_side <= pwdata[SIDE_W-1:0];
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == ST_FIN) && (!r_ov || i_out_ready);
    assign w_last     = ({1'b0, r_j} + 1'b1) == r_count;
    assign w_we       = w_load && !r_clr && !r_hit && (r_count < CNT_W'(MAX_SQUARES));

    assign w_side_a = MA_W'(r_side);
    assign w_side_b = MB_W'(r_side);
    assign w_hc     = half_round(r_p[0]);
    assign w_hs     = half_round(r_p[1]);
    assign w_shc    = half_round(r_p[2]);
    assign w_shs    = half_round(r_p[3]);
    assign w_dx     = (COORD_W+1)'(r_cx) - (COORD_W+1)'(r_q.cx);
    assign w_dy     = (COORD_W+1)'(r_cy) - (COORD_W+1)'(r_q.cy);
    assign w_dist   = r_p[0] + r_p[1];
    assign w_close  = w_dist < (PROD_W+1)'({r_side2, 1'b0});

    // corner under test and the frame it is checked against
    always_comb begin
        if (!r_k[2]) begin
            w_px  = r_nx[r_k[1:0]];
            w_py  = r_ny[r_k[1:0]];
            w_ax  = PT_W'(r_q.cx);
            w_ay  = PT_W'(r_q.cy);
            w_fco = r_q.co;
            w_fsi = r_q.si;
        end else begin
            w_px  = r_ox[r_k[1:0]];
            w_py  = r_oy[r_k[1:0]];
            w_ax  = PT_W'(r_cx);
            w_ay  = PT_W'(r_cy);
            w_fco = r_co;
            w_fsi = r_si;
        end
    end

    assign w_tx  = (PT_W+1)'(w_px) - (PT_W+1)'(w_ax);
    assign w_ty  = (PT_W+1)'(w_py) - (PT_W+1)'(w_ay);
    assign w_rx  = r_p[0] + r_p[1];
    assign w_ry  = r_p[2] - r_p[3];
    assign w_ax2 = w_rx[PROD_W] ? -w_rx : w_rx;
    assign w_ay2 = w_ry[PROD_W] ? -w_ry : w_ry;
    assign w_lim = (PROD_W+2)'({r_side, 16'h0000});
    assign w_hit = r_kv && ({w_ax2, 1'b0} < w_lim) && ({w_ay2, 1'b0} < w_lim);

    // shared multipliers
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            n_ma[m] = '0;
            n_mb[m] = '0;
        end
        case (r_state)
            ST_PROD: begin
                n_ma[0] = w_side_a; n_mb[0] = MB_W'(r_co);
                n_ma[1] = w_side_a; n_mb[1] = MB_W'(r_si);
                n_ma[2] = w_side_a; n_mb[2] = w_side_b;
            end
            ST_EPROD: begin
                n_ma[0] = MA_W'(w_dx); n_mb[0] = MB_W'(w_dx);
                n_ma[1] = MA_W'(w_dy); n_mb[1] = MB_W'(w_dy);
                n_ma[2] = w_side_a;    n_mb[2] = MB_W'(r_q.co);
                n_ma[3] = w_side_a;    n_mb[3] = MB_W'(r_q.si);
            end
            ST_TEST: begin
                n_ma[0] = MA_W'(w_tx); n_mb[0] = MB_W'(w_fco);
                n_ma[1] = MA_W'(w_ty); n_mb[1] = MB_W'(w_fsi);
                n_ma[2] = MA_W'(w_ty); n_mb[2] = MB_W'(w_fco);
                n_ma[3] = MA_W'(w_tx); n_mb[3] = MB_W'(w_fsi);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < 4; m++) begin
            r_p[m] <= n_ma[m] * n_mb[m];
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IDX_W-1:0]] <= '{cx: r_cx, cy: r_cy, co: r_co, si: r_si};
        end
        r_q <= r_mem[r_j];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = (i_op == OP_CLEAR) ? ST_FIN : ST_CORD;
            ST_CORD:  if (w_cord_done) n_state = ST_PROD;
            ST_PROD:  n_state = ST_OWN;
            ST_OWN:   n_state = (r_count == '0) ? ST_FIN : ST_RD;
            ST_RD:    n_state = ST_EPROD;
            ST_EPROD: n_state = ST_ECHK;
            ST_ECHK: begin
                if (w_close) begin
                    n_state = ST_TEST;
                end else begin
                    n_state = w_last ? ST_FIN : ST_RD;
                end
            end
            ST_TEST: begin
                if (w_hit) begin
                    n_state = ST_FIN;
                end else if (r_k[3]) begin
                    n_state = w_last ? ST_FIN : ST_RD;
                end
            end
            ST_FIN:   if (w_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_clr   <= 1'b0;
            r_hit   <= 1'b0;
            r_kv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_clr <= (i_op == OP_CLEAR);
                        r_hit <= 1'b0;
                    end
                end
                ST_ECHK: begin
                    r_kv <= 1'b0;
                end
                ST_TEST: begin
                    r_kv <= !r_k[3];
                    if (w_hit) begin
                        r_hit <= 1'b1;
                    end
                end
                ST_FIN: begin
                    if (w_load) begin
                        if (r_clr) begin
                            r_count <= '0;
                        end else if (w_we) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
        end
        if (r_state == ST_CORD && w_cord_done) begin
            r_co <= w_cos;
            r_si <= w_sin;
        end
        if (r_state == ST_OWN) begin
            r_side2 <= r_p[2][47:0];
            r_j     <= '0;
            for (int k = 0; k < 4; k++) begin
                r_nx[k] <= corner_x(r_cx, w_hc, w_hs, 2'(k));
                r_ny[k] <= corner_y(r_cy, w_hc, w_hs, 2'(k));
            end
        end
        if (r_state == ST_ECHK) begin
            r_k <= '0;
            for (int k = 0; k < 4; k++) begin
                r_ox[k] <= corner_x(r_q.cx, w_shc, w_shs, 2'(k));
                r_oy[k] <= corner_y(r_q.cy, w_shc, w_shs, 2'(k));
            end
            if (!w_close && !w_last) begin
                r_j <= r_j + 1'b1;
            end
        end
        if (r_state == ST_TEST && !w_hit) begin
            r_k <= r_k + 1'b1;
            if (r_k[3] && !w_last) begin
                r_j <= r_j + 1'b1;
            end
        end
        if (w_load) begin
            if (r_clr) begin
                r_status <= STATUS_CLEARED;
            end else if (r_hit) begin
                r_status <= STATUS_OVERLAP;
            end else if (w_we) begin
                r_status <= STATUS_ACCEPTED;
            end else begin
                r_status <= STATUS_FULL;
            end
            r_slot <= w_we ? r_count[7:0] : 8'd0;
            for (int k = 0; k < 4; k++) begin
                r_ocx[k] <= r_clr ? '0 : sat24(r_nx[k]);
                r_ocy[k] <= r_clr ? '0 : sat24(r_ny[k]);
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_corner_a_x = r_ocx[0];
    assign o_corner_a_y = r_ocy[0];
    assign o_corner_b_x = r_ocx[1];
    assign o_corner_b_y = r_ocy[1];
    assign o_corner_c_x = r_ocx[2];
    assign o_corner_c_y = r_ocy[2];
    assign o_corner_d_x = r_ocx[3];
    assign o_corner_d_y = r_ocy[3];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SQUARES))
        else $error("accepted count beyond table size");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST || r_state == ST_ECHK) |-> ({1'b0, r_j} < r_count))
        else $error("scan index past accepted count");

    a_clear_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_CLEAR) |=> (r_state == ST_FIN && r_clr))
        else $error("clear request did not go straight to result");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_clr) |=> (r_count == '0))
        else $error("clear did not empty table");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + 1'b1))
        else $error("stored square did not advance count");
`endif

endmodule
`default_nettype wire
